[rtl/dlharq_pkg.sv]
// shared types, constants and helpers for the downlink harq tracker
`timescale 1ns / 1ps
package dlharq_pkg;

    localparam int NUM_PROCESSES   = 8;
    localparam int NUM_BLOCKS      = 2;
    localparam int DUPLICATE_LIMIT = 2;
    localparam int NUM_ENTRIES     = (NUM_PROCESSES + 1) * NUM_BLOCKS;
    localparam int ENTRY_W         = $clog2(NUM_ENTRIES);
    localparam int PROC_W          = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int QUEUE_DEPTH     = 2;
    localparam logic [15:0] SI_RNTI = 16'hFFFF;

    localparam logic [1:0] OP_GRANT  = 2'd0;
    localparam logic [1:0] OP_DECODE = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    localparam logic [1:0] KIND_BCAST = 2'd0;
    localparam logic [1:0] KIND_TEMP  = 2'd1;
    localparam logic [1:0] KIND_SIDE  = 2'd2;
    localparam logic [1:0] KIND_NORM  = 2'd3;

    localparam logic [1:0] REG_SPS  = 2'd0;
    localparam logic [1:0] REG_TEMP = 2'd1;
    localparam logic [1:0] REG_SIW  = 2'd2;
    localparam logic [1:0] REG_SIDE = 2'd3;

    typedef struct packed {
        logic        ndi;
        logic        first;
        logic        ack;
        logic        pending;
        logic [3:0]  gap;
        logic [7:0]  retx;
        logic [13:0] tbs;
        logic [13:0] tti;
        logic [15:0] rnti;
    } entry_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]         op;
        logic               err;
        logic               side;
        logic               bc;
        logic [ENTRY_W-1:0] idx;
        logic               clr_first;
        logic [ENTRY_W-1:0] clr_base;
        logic               absent;
        logic [13:0]        tbs;
        logic [1:0]         rv;
        logic               rv_zero;
        logic               ndi_valid;
        logic               ndi;
        logic [13:0]        tti;
        logic [3:0]         gap;
        logic [15:0]        rnti;
        logic               ok;
        logic               expired;
    } cmd_t;

    typedef struct packed {
        logic       error;
        logic       decode_enable;
        logic [1:0] rv_out;
        logic       ack_req;
        logic       new_transmission;
        logic       reset_soft_buffer;
        logic [7:0] retx_count;
        logic       deliver;
        logic [1:0] deliver_kind;
    } res_t;

    function automatic entry_t cleared_entry();
        entry_t e;
        e       = '0;
        e.first = 1'b1;
        return e;
    endfunction

endpackage

[rtl/dlharq_front.sv]
// front end: classifies items, derives broadcast rv and tracks temporary rnti
`timescale 1ns / 1ps
module dlharq_front import dlharq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] rnti,
    input  logic [13:0] pid,
    input  logic        tb_index,
    input  logic [13:0] tbs,
    input  logic [2:0]  rv,
    input  logic        ndi_valid,
    input  logic        ndi,
    input  logic [13:0] sl_tti,
    input  logic [3:0]  sl_gap,
    input  logic        decoded_ok,
    input  logic        align_expired,
    input  logic [15:0] sps_id,
    input  logic [15:0] tmp_id,
    input  logic [13:0] si_win_start,
    input  logic [15:0] side_id,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    cmd_t        q_reg [QUEUE_DEPTH];
    logic [1:0]  cnt_reg, cnt_next;
    logic        wp_reg, rp_reg;
    logic [15:0] last_temp_reg;
    cmd_t        c;
    logic        push, pop;
    logic [PROC_W-1:0] p;
    logic [13:0] pid_div10, rem10, pid_div20, diffv;
    logic [1:0]  k, brv;
    logic        upd_temp;

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = q_reg[rp_reg];

    // reciprocal multiply for /10 over the whole 14-bit pid, one fixup
    always_comb begin
        logic [27:0] m;
        m         = 28'(pid) * 28'd6554;
        pid_div10 = 14'(m >> 16);
        if (14'(pid_div10 * 14'd10) > pid) pid_div10 = pid_div10 - 14'd1;
        rem10     = pid - 14'(pid_div10 * 14'd10);
        pid_div20 = pid_div10 >> 1;
        diffv     = pid - si_win_start;
        if (!pid_div10[0] && rem10 == 14'd5) k = pid_div20[1:0];
        else k = diffv[1:0];
        case (k)
            2'd0:    brv = 2'd0;
            2'd1:    brv = 2'd2;
            2'd2:    brv = 2'd3;
            default: brv = 2'd1;
        endcase
    end

    always_comb begin
        c             = '0;
        upd_temp      = 1'b0;
        c.op          = op;
        c.tbs         = tbs;
        c.ndi_valid   = ndi_valid;
        c.ndi         = ndi;
        c.tti         = sl_tti;
        c.gap         = sl_gap;
        c.rnti        = rnti;
        c.ok          = decoded_ok;
        c.expired     = align_expired;
        c.absent      = (tbs == 14'd0);
        c.rv          = rv[1:0];
        c.rv_zero     = (rv == 3'd0);
        p             = PROC_W'(pid % NUM_PROCESSES);
        if (op == OP_GRANT || op == OP_DECODE) begin
            if (32'(tb_index) >= NUM_BLOCKS) begin
                c.err = 1'b1;
            end else if (op == OP_GRANT) begin
                if (rnti == side_id) begin
                    c.side = 1'b1;
                    c.idx  = ENTRY_W'(32'(p) * NUM_BLOCKS + 32'(tb_index));
                end else if (rnti == sps_id) begin
                    c.err = 1'b1;
                end else if (rnti != SI_RNTI && 32'(pid) >= NUM_PROCESSES) begin
                    c.err = 1'b1;
                end else begin
                    c.bc = (rnti == SI_RNTI);
                    if (c.bc) begin
                        c.clr_base = ENTRY_W'(NUM_PROCESSES * NUM_BLOCKS);
                        if (rv == 3'b111) begin
                            c.rv      = brv;
                            c.rv_zero = (brv == 2'd0);
                        end
                    end else begin
                        c.clr_base = ENTRY_W'(32'(pid) * NUM_BLOCKS);
                    end
                    c.idx = ENTRY_W'(32'(c.clr_base) + 32'(tb_index));
                    if (rnti == tmp_id && last_temp_reg != tmp_id) begin
                        c.clr_first = 1'b1;
                        upd_temp    = 1'b1;
                    end
                end
            end else begin
                c.bc = (rnti == SI_RNTI);
                if (!c.bc && 32'(pid) >= NUM_PROCESSES) c.err = 1'b1;
                else if (c.bc)
                    c.idx = ENTRY_W'(NUM_PROCESSES * NUM_BLOCKS + 32'(tb_index));
                else c.idx = ENTRY_W'(32'(pid) * NUM_BLOCKS + 32'(tb_index));
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (!push && pop) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            wp_reg        <= 1'b0;
            rp_reg        <= 1'b0;
            last_temp_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wp_reg <= ~wp_reg;
                if (upd_temp) last_temp_reg <= tmp_id;
            end
            if (pop) rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= c;
    end

endmodule

[rtl/dlharq_back.sv]
// back end: read-modify-write of the harq entry table and result register
`timescale 1ns / 1ps
module dlharq_back import dlharq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    input  logic [15:0] tmp_id,
    input  logic [15:0] side_id,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    entry_t tab_reg [NUM_ENTRIES];
    res_t   res_reg;
    logic   res_v_reg;
    entry_t e, en;
    res_t   r;
    logic   newtx, rst_sb;

    assign q_ready   = !res_v_reg || res_ready;
    assign res_valid = res_v_reg;
    assign res       = res_reg;

    always_comb begin
        e = tab_reg[q_cmd.idx];
        if (q_cmd.clr_first) e.first = 1'b1;
        en     = e;
        r      = '0;
        newtx  = 1'b0;
        rst_sb = 1'b0;
        if (q_cmd.err) begin
            r.error = 1'b1;
        end else if (q_cmd.op == OP_GRANT && !q_cmd.absent) begin
            if (q_cmd.side) begin
                newtx = q_cmd.ndi_valid && q_cmd.ndi;
            end else if ((q_cmd.ndi_valid && q_cmd.ndi != e.ndi) ||
                         (q_cmd.bc && q_cmd.rv_zero) || e.first) begin
                en.first = 1'b0;
                newtx    = 1'b1;
            end
            if (newtx || e.tbs != q_cmd.tbs) rst_sb = 1'b1;
            if (!newtx && (15'(e.tti) + 15'(e.gap)) != 15'(q_cmd.tti)) rst_sb = 1'b1;
            if (rst_sb) begin
                en.ack  = 1'b0;
                en.retx = '0;
            end
            if (en.retx != 8'hFF) en.retx = en.retx + 8'd1;
            if (!en.ack) begin
                en.ndi     = q_cmd.ndi;
                en.tbs     = q_cmd.tbs;
                en.tti     = q_cmd.tti;
                en.gap     = q_cmd.gap;
                en.rnti    = q_cmd.rnti;
                en.pending = 1'b1;
                r.decode_enable = 1'b1;
                r.rv_out        = q_cmd.rv;
            end else if (32'(en.retx) > DUPLICATE_LIMIT) begin
                en = cleared_entry();
            end
            r.ack_req           = !q_cmd.bc && !q_cmd.expired;
            r.new_transmission  = newtx;
            r.reset_soft_buffer = rst_sb;
            r.retx_count        = en.retx;
        end else if (q_cmd.op == OP_DECODE) begin
            if (e.pending) begin
                en.ack = q_cmd.ok;
                if (q_cmd.ok) begin
                    r.deliver = 1'b1;
                    if (q_cmd.bc) r.deliver_kind = KIND_BCAST;
                    else if (e.rnti == tmp_id) r.deliver_kind = KIND_TEMP;
                    else if (e.rnti == side_id) r.deliver_kind = KIND_SIDE;
                    else r.deliver_kind = KIND_NORM;
                end
                en.pending = 1'b0;
            end
            r.retx_count = e.retx;
            if (en.ack && q_cmd.bc) en = cleared_entry();
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_v_reg <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++) tab_reg[i] <= cleared_entry();
        end else begin
            res_v_reg <= (q_valid && q_ready) || (res_v_reg && !res_ready);
            if (q_valid && q_ready) begin
                res_reg   <= r;
                if (q_cmd.op == OP_RESET) begin
                    for (int i = 0; i < NUM_ENTRIES; i++) tab_reg[i] <= cleared_entry();
                end else if (!q_cmd.err && (q_cmd.op == OP_GRANT || q_cmd.op == OP_DECODE)) begin
                    // other blocks of the process; the addressed block comes from en
                    if (q_cmd.clr_first) begin
                        for (int b = 0; b < NUM_BLOCKS; b++)
                            if (ENTRY_W'(32'(q_cmd.clr_base) + b) != q_cmd.idx)
                                tab_reg[ENTRY_W'(32'(q_cmd.clr_base) + b)].first <= 1'b1;
                    end
                    tab_reg[q_cmd.idx] <= en;
                end
            end
        end
    end

endmodule

[rtl/dl_harq_process_tracker.sv]
// top level of the downlink harq process tracker with apb register file
`timescale 1ns / 1ps
// an accepted word is queued in the front, then the back end registers its result word
// throughput: one word per cycle through the front queue, one table update per cycle in the back,
// unless m_tready stalls; one read-modify-write per word in the flip-flop table sets the rate
// reset: synchronous active-low aresetn clears registers, queue and table (first flags set)
module dl_harq_process_tracker import dlharq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[1:0] rnti[17:2] pid[31:18] tb_index[32] tbs[46:33] rv[49:47]
    // ndi_valid[50] ndi[51] sl_tti[65:52] sl_gap[69:66] decoded_ok[70]
    // align_expired[71]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // error[0] decode_enable[1] rv_out[3:2] ack_req[4] new_transmission[5]
    // reset_soft_buffer[6] retx_count[14:7] deliver[15] deliver_kind[17:16]
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] sps_reg, temp_reg, side_reg;
    logic [13:0] siw_reg;
    logic        q_valid, q_ready;
    cmd_t        q_cmd;
    res_t        r;

    assign pready = 1'b1;

    // register writes in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sps_reg  <= '0;
            temp_reg <= '0;
            siw_reg  <= '0;
            side_reg <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[1:0] == 2'd0) begin
                case (paddr[3:2])
                    REG_SPS:  sps_reg  <= pwdata[15:0];
                    REG_TEMP: temp_reg <= pwdata[15:0];
                    REG_SIW:  siw_reg  <= pwdata[13:0];
                    REG_SIDE: side_reg <= pwdata[15:0];
                    default:  ;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SPS:  prdata = {16'd0, sps_reg};
            REG_TEMP: prdata = {16'd0, temp_reg};
            REG_SIW:  prdata = {18'd0, siw_reg};
            REG_SIDE: prdata = {16'd0, side_reg};
            default:  prdata = '0;
        endcase
    end

    // front: classify and queue
    dlharq_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .op              (s_tdata[1:0]),
        .rnti            (s_tdata[17:2]),
        .pid             (s_tdata[31:18]),
        .tb_index        (s_tdata[32]),
        .tbs             (s_tdata[46:33]),
        .rv              (s_tdata[49:47]),
        .ndi_valid       (s_tdata[50]),
        .ndi             (s_tdata[51]),
        .sl_tti          (s_tdata[65:52]),
        .sl_gap          (s_tdata[69:66]),
        .decoded_ok      (s_tdata[70]),
        .align_expired   (s_tdata[71]),
        .sps_id          (sps_reg),
        .tmp_id          (temp_reg),
        .si_win_start    (siw_reg),
        .side_id         (side_reg),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_cmd           (q_cmd)
    );

    // back: table update and result register
    dlharq_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd),
        .tmp_id        (temp_reg),
        .side_id       (side_reg),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res           (r)
    );

    assign m_tdata = {6'd0, r.deliver_kind, r.deliver, r.retx_count, r.reset_soft_buffer,
                      r.new_transmission, r.ack_req, r.rv_out, r.decode_enable,
                      r.error};

endmodule

[tb/sv/dl_harq_process_tracker_tb.sv]
// self-checking testbench for the downlink harq process tracker
`timescale 1ns / 1ps
module dl_harq_process_tracker_tb import dlharq_pkg::*; ();

    // op code with no action, not named in the package
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 226;

    // expected-result table: mirror of the harq entries plus the register copies
    class harq_scoreboard;
        entry_t      table_m[NUM_ENTRIES];
        logic [15:0] last_temp;
        logic [15:0] sps_id, tmp_id, side_rnti;
        logic [13:0] si_start;
        res_t        pending_res[$];
        int          mismatches;

        function void wipe_entries();
            foreach (table_m[i]) begin
                table_m[i]       = '0;
                table_m[i].first = 1'b1;
            end
        endfunction

        function void power_on();
            wipe_entries();
            last_temp = '0;
            sps_id    = '0;
            tmp_id    = '0;
            side_rnti = '0;
            si_start  = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_SPS:  sps_id    = val[15:0];
                REG_TEMP: tmp_id    = val[15:0];
                REG_SIW:  si_start  = val[13:0];
                REG_SIDE: side_rnti = val[15:0];
                default: ;
            endcase
        endfunction

        function res_t grant_result(logic [15:0] rnti, int unsigned pid, int unsigned tb,
                                    int unsigned tbs, logic [2:0] rv3, logic ndi_p, logic ndi,
                                    int unsigned tti, int unsigned gap, logic expired);
            res_t        r;
            entry_t      e;
            logic        side, bc, newtx;
            int unsigned p, idx, k;
            int          rv;
            r    = '0;
            side = (rnti == side_rnti);
            bc   = 1'b0;
            rv   = int'($signed(rv3));
            if (side) begin
                p = pid % NUM_PROCESSES;
            end else begin
                if (rnti == sps_id) begin
                    r.error = 1'b1;
                    return r;
                end
                if (rnti == SI_RNTI) begin
                    bc = 1'b1;
                    p  = NUM_PROCESSES;
                end else if (pid >= NUM_PROCESSES) begin
                    r.error = 1'b1;
                    return r;
                end else begin
                    p = pid;
                end
                // first sight of a new temporary rnti marks the whole process fresh
                if (rnti == tmp_id && last_temp != tmp_id) begin
                    last_temp = tmp_id;
                    for (int b = 0; b < NUM_BLOCKS; b++)
                        table_m[p * NUM_BLOCKS + b].first = 1'b1;
                end
            end
            if (tbs == 0)
                return r;
            idx = p * NUM_BLOCKS + tb;
            e   = table_m[idx];
            // broadcast rv derived from the subframe when not given
            if (bc && rv == -1) begin
                if ((pid / 10) % 2 == 0 && pid % 10 == 5)
                    k = (pid / 20) % 4;
                else
                    k = (pid - int'(si_start)) & 3;
                case (k)
                    0: rv = 0;
                    1: rv = 2;
                    2: rv = 3;
                    default: rv = 1;
                endcase
            end
            if (side) begin
                newtx = ndi_p & ndi;
            end else if ((ndi_p && ndi != e.ndi) || (bc && rv == 0) || e.first) begin
                e.first = 1'b0;
                newtx   = 1'b1;
            end else begin
                newtx = 1'b0;
            end
            if (newtx || int'(e.tbs) != tbs) begin
                e.ack = 1'b0;
                e.retx = '0;
                r.reset_soft_buffer = 1'b1;
            end
            if (!newtx && int'(e.tti) + int'(e.gap) != tti) begin
                e.ack = 1'b0;
                e.retx = '0;
                r.reset_soft_buffer = 1'b1;
            end
            if (e.retx != 8'd255)
                e.retx++;
            if (!e.ack) begin
                e.ndi     = ndi;
                e.tbs     = tbs[13:0];
                e.tti     = tti[13:0];
                e.gap     = gap[3:0];
                e.rnti    = rnti;
                e.pending = 1'b1;
                r.decode_enable = 1'b1;
                r.rv_out  = rv[1:0];
            end else if (e.retx > DUPLICATE_LIMIT) begin
                // duplicate beyond the limit drops the entry, soft buffer untouched
                e       = '0;
                e.first = 1'b1;
            end
            r.ack_req          = !bc && !expired;
            r.new_transmission = newtx;
            r.retx_count       = e.retx;
            table_m[idx] = e;
            return r;
        endfunction

        function res_t decode_result(logic [15:0] rnti, int unsigned pid, int unsigned tb,
                                     logic ok);
            res_t        r;
            logic        bc;
            int unsigned idx;
            r  = '0;
            bc = (rnti == SI_RNTI);
            if (!bc && pid >= NUM_PROCESSES) begin
                r.error = 1'b1;
                return r;
            end
            idx = (bc ? NUM_PROCESSES : pid) * NUM_BLOCKS + tb;
            if (table_m[idx].pending) begin
                table_m[idx].ack = ok;
                if (ok) begin
                    r.deliver = 1'b1;
                    if (bc)                                r.deliver_kind = KIND_BCAST;
                    else if (table_m[idx].rnti == tmp_id)    r.deliver_kind = KIND_TEMP;
                    else if (table_m[idx].rnti == side_rnti) r.deliver_kind = KIND_SIDE;
                    else                                   r.deliver_kind = KIND_NORM;
                end
                table_m[idx].pending = 1'b0;
            end
            r.retx_count = table_m[idx].retx;
            // acked broadcast entry is released once the count has been reported
            if (table_m[idx].ack && bc) begin
                table_m[idx]       = '0;
                table_m[idx].first = 1'b1;
            end
            return r;
        endfunction

        function void note_input(logic [71:0] w);
            res_t        r;
            logic [1:0]  op;
            int unsigned tb;
            op = w[1:0];
            tb = w[32];
            r  = '0;
            if (op == OP_RESET)
                wipe_entries();
            else if (op == OP_NONE)
                r = '0;
            else if (tb >= NUM_BLOCKS)
                r.error = 1'b1;
            else if (op == OP_GRANT)
                r = grant_result(w[17:2], w[31:18], tb, w[46:33], w[49:47], w[50], w[51],
                                 w[65:52], w[69:66], w[71]);
            else
                r = decode_result(w[17:2], w[31:18], tb, w[70]);
            pending_res.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(logic [23:0] d);
            res_t r;
            if (pending_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", d);
                return;
            end
            r = pending_res.pop_front();
            compare_field("error",             r.error,             d[0]);
            compare_field("decode_enable",     r.decode_enable,     d[1]);
            compare_field("rv_out",            r.rv_out,            d[3:2]);
            compare_field("ack_req",           r.ack_req,           d[4]);
            compare_field("new_transmission",  r.new_transmission,  d[5]);
            compare_field("reset_soft_buffer", r.reset_soft_buffer, d[6]);
            compare_field("retx_count",        r.retx_count,        d[14:7]);
            compare_field("deliver",           r.deliver,           d[15]);
            compare_field("deliver_kind",      r.deliver_kind,      d[17:16]);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // op, rnti, pid, tb_index, tbs, rv, ndi_valid, ndi, sl_tti, sl_gap, decoded_ok,
    // align_expired from bit 0 up
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // error, decode_enable, rv_out, ack_req, new_transmission, reset_soft_buffer,
    // retx_count, deliver, deliver_kind from bit 0 up
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    harq_scoreboard harq_sb;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;

    dl_harq_process_tracker dut (.*);

    always #5 aclk = ~aclk;

    // monitor: inputs noted and results checked at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                harq_sb.note_input(s_tdata);
            if (m_tvalid && m_tready)
                harq_sb.check_result(m_tdata);
        end
    end

    // result side: random stalls, plus one long hold-off when asked
    always @(negedge aclk) begin
        if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // overall watchdog
    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [71:0] pack_word(logic [1:0] op, logic [15:0] rnti,
                                              logic [13:0] pid, logic tb, logic [13:0] tbs,
                                              logic [2:0] rv, logic ndi_p, logic ndi,
                                              logic [13:0] tti, logic [3:0] gap, logic ok,
                                              logic expired);
        return {expired, ok, gap, tti, ndi, ndi_p, rv, tbs, tb, pid, rnti, op};
    endfunction

    // called at a falling edge, returns at a falling edge after the word is taken
    task automatic send_word(logic [71:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // leaves the bus idle after the write so back-to-back writes never clash
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        harq_sb.set_reg(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // drain everything outstanding, then let the table settle before returning
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (harq_sb.pending_res.size() != 0 && guard < 50000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_regs(logic [15:0] sps, logic [15:0] tmp, logic [13:0] siw,
                            logic [15:0] side);
        wait_drained();
        write_reg(REG_SPS,  sps);
        write_reg(REG_TEMP, tmp);
        write_reg(REG_SIW,  siw);
        write_reg(REG_SIDE, side);
    endtask

    function automatic logic [15:0] pick_rnti();
        case ($urandom_range(9))
            0: return harq_sb.sps_id;
            1: return harq_sb.tmp_id;
            2, 3: return SI_RNTI;
            4: return harq_sb.side_rnti;
            5: return 16'($urandom);
            default: return 16'($urandom_range(100, 103));
        endcase
    endfunction

    // one harq process lifetime: grant, retransmissions, decode, maybe duplicates
    task automatic send_sequence(ref int count);
        logic [15:0] rnti;
        logic [13:0] pid, tbs, tti;
        logic [3:0]  gap;
        logic        tb, ndi;
        int          n;
        rnti = pick_rnti();
        if (rnti == SI_RNTI)
            pid = ($urandom_range(3) == 0) ? 14'($urandom_range(0, 40)) :
                                             14'($urandom_range(0, 10239));
        else if ($urandom_range(19) == 0)
            pid = 14'($urandom);
        else
            pid = 14'($urandom_range(0, NUM_PROCESSES - 1));
        tb  = 1'($urandom);
        tbs = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(1, 64));
        ndi = 1'($urandom);
        tti = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(0, 10000));
        gap = 4'($urandom);
        n   = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            send_word(pack_word(OP_GRANT, rnti, pid, tb,
                                ($urandom_range(15) == 0) ? 14'($urandom_range(1, 64)) : tbs,
                                (k == 0) ? 3'($urandom_range(0, 7) == 0 ? 7 : 0) : 3'($urandom),
                                ($urandom_range(7) != 0), ndi, tti, gap, 1'($urandom),
                                ($urandom_range(5) == 0)));
            count++;
            // retransmissions land on the expected subframe most of the time
            tti = ($urandom_range(7) == 0) ? 14'($urandom) : tti + gap;
            if ($urandom_range(3) == 0) begin
                send_word(pack_word(OP_DECODE, rnti, pid, tb, 14'($urandom), 3'($urandom),
                                    1'($urandom), 1'($urandom), 14'($urandom), 4'($urandom),
                                    1'b0, 1'($urandom)));
                count++;
            end
        end
        send_word(pack_word(OP_DECODE, rnti, pid, tb, 14'($urandom), 3'($urandom),
                            1'($urandom), 1'($urandom), 14'($urandom), 4'($urandom),
                            ($urandom_range(9) < 7), 1'($urandom)));
        count++;
        // repeated grant after ack exercises the duplicate path
        repeat ($urandom_range(0, 3)) begin
            send_word(pack_word(OP_GRANT, rnti, pid, tb, tbs, 3'($urandom), 1'b1, ndi,
                                tti, gap, 1'b0, 1'b0));
            tti = tti + gap;
            count++;
        end
    endtask

    task automatic random_phase(int target);
        int count;
        count = 0;
        while (count < target) begin
            case ($urandom_range(19))
                0: begin
                    send_word(pack_word(2'($urandom_range(2, 3)), 16'($urandom),
                                        14'($urandom), 1'($urandom), 14'($urandom),
                                        3'($urandom), 1'($urandom), 1'($urandom),
                                        14'($urandom), 4'($urandom), 1'($urandom),
                                        1'($urandom)));
                    count++;
                end
                1, 2: begin
                    // noise: random grant or decode with a picked rnti
                    send_word(pack_word(2'($urandom_range(0, 1)), pick_rnti(),
                                        14'($urandom), 1'($urandom), 14'($urandom),
                                        3'($urandom), 1'($urandom), 1'($urandom),
                                        14'($urandom), 4'($urandom), 1'($urandom),
                                        1'($urandom)));
                    count++;
                end
                default: send_sequence(count);
            endcase
            if (count > 40 && hold_req == 1'b0 && stall_pct < 0)
                hold_req = 1'b1;
        end
    endtask

    initial begin
        harq_sb = new();
        harq_sb.power_on();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part with reset register values: rnti 0 is the side link one
        send_word(pack_word(OP_GRANT, 16'd0, 14'd16383, 1'b1, 14'd16383, 3'd0, 1'b1, 1'b1,
                            14'd16383, 4'd15, 1'b0, 1'b0));
        send_word(pack_word(OP_DECODE, 16'd0, 14'd9, 1'b1, 14'd0, 3'd0, 1'b0, 1'b0,
                            14'd0, 4'd0, 1'b1, 1'b0));
        set_regs(16'h1234, 16'h0042, 14'd0, 16'h0777);
        // bad pid, sps reject, absent block on temporary rnti
        send_word(pack_word(OP_GRANT, 16'd100, 14'd8, 1'b0, 14'd10, 3'd0, 1'b1, 1'b0,
                            14'd0, 4'd0, 1'b0, 1'b0));
        send_word(pack_word(OP_GRANT, 16'h1234, 14'd1, 1'b0, 14'd10, 3'd0, 1'b1, 1'b0,
                            14'd0, 4'd0, 1'b0, 1'b0));
        send_word(pack_word(OP_GRANT, 16'h0042, 14'd2, 1'b0, 14'd0, 3'd0, 1'b1, 1'b1,
                            14'd0, 4'd0, 1'b0, 1'b0));
        // decode with nothing pending
        send_word(pack_word(OP_DECODE, 16'd100, 14'd3, 1'b0, 14'd0, 3'd0, 1'b0, 1'b0,
                            14'd0, 4'd0, 1'b1, 1'b0));
        // broadcast with derived rv: special subframes and ordinary ones, and rv -2
        send_word(pack_word(OP_GRANT, SI_RNTI, 14'd5, 1'b0, 14'd20, 3'b111, 1'b0, 1'b0,
                            14'd0, 4'd0, 1'b0, 1'b0));
        send_word(pack_word(OP_GRANT, SI_RNTI, 14'd25, 1'b0, 14'd20, 3'b111, 1'b0, 1'b0,
                            14'd0, 4'd0, 1'b0, 1'b0));
        send_word(pack_word(OP_GRANT, SI_RNTI, 14'd10239, 1'b1, 14'd20, 3'b111, 1'b0, 1'b0,
                            14'd0, 4'd0, 1'b0, 1'b0));
        send_word(pack_word(OP_GRANT, SI_RNTI, 14'd7, 1'b1, 14'd20, 3'b110, 1'b0, 1'b0,
                            14'd0, 4'd0, 1'b0, 1'b0));
        send_word(pack_word(OP_DECODE, SI_RNTI, 14'd7, 1'b1, 14'd0, 3'd0, 1'b0, 1'b0,
                            14'd0, 4'd0, 1'b1, 1'b0));
        // normal grant, retx on time, retx off time, ack, then repeats: the first is off time, resets soft buffer
        send_word(pack_word(OP_GRANT, 16'd101, 14'd4, 1'b1, 14'd50, 3'd0, 1'b1, 1'b1,
                            14'd100, 4'd8, 1'b0, 1'b1));
        send_word(pack_word(OP_GRANT, 16'd101, 14'd4, 1'b1, 14'd50, 3'd2, 1'b1, 1'b1,
                            14'd108, 4'd8, 1'b0, 1'b0));
        send_word(pack_word(OP_GRANT, 16'd101, 14'd4, 1'b1, 14'd50, 3'd3, 1'b1, 1'b1,
                            14'd999, 4'd8, 1'b0, 1'b0));
        send_word(pack_word(OP_DECODE, 16'd101, 14'd4, 1'b1, 14'd0, 3'd0, 1'b0, 1'b0,
                            14'd0, 4'd0, 1'b1, 1'b0));
        repeat (3)
            send_word(pack_word(OP_GRANT, 16'd101, 14'd4, 1'b1, 14'd50, 3'd1, 1'b1, 1'b1,
                                14'd999, 4'd0, 1'b0, 1'b0));
        send_word(pack_word(OP_RESET, 16'd0, 14'd0, 1'b0, 14'd0, 3'd0, 1'b0, 1'b0,
                            14'd0, 4'd0, 1'b0, 1'b0));
        send_word(pack_word(OP_NONE, 16'hFFFF, 14'd16383, 1'b1, 14'd16383, 3'd7, 1'b1,
                            1'b1, 14'd16383, 4'd15, 1'b1, 1'b1));

        // random phases, each with its own register setting and idling pattern
        send_idle_pct = 0;  stall_pct = 0;
        random_phase(PHASE_ITEMS);
        set_regs(16'hFFFF, 16'h0000, 14'd10239, 16'h0000);
        send_idle_pct = 48; stall_pct = 0;
        random_phase(PHASE_ITEMS);
        set_regs(16'h0000, 16'hFFFF, 14'd5000, 16'hFFFF);
        send_idle_pct = 0;  stall_pct = 48;
        random_phase(PHASE_ITEMS);
        set_regs(16'h0100, 16'h0043, 14'd3, 16'h0200);
        send_idle_pct = 22; stall_pct = 22;
        random_phase(PHASE_ITEMS);
        // long receiver hold-off while words keep coming, so the input backs up
        set_regs(16'h0101, 16'h0044, 14'd9, 16'h0201);
        send_idle_pct = 0;  stall_pct = 0;
        random_phase(40);
        hold_req = 1'b1;
        random_phase(PHASE_ITEMS - 40);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (harq_sb.mismatches == 0 && harq_sb.pending_res.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/dlharq_pkg.sv
rtl/dlharq_front.sv
rtl/dlharq_back.sv
rtl/dl_harq_process_tracker.sv
tb/sv/dl_harq_process_tracker_tb.sv
